/* hdl/fwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fwc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned HALF_W     = 15;
  localparam int unsigned EDGE_W     = COORD_W + 1;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_Z = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    logic         on_ground;
    edge_t [2:0]  lo;
    edge_t [2:0]  hi;
  } entry_t;

  typedef struct packed {
    edge_t [2:0]  lo;
    edge_t [2:0]  hi;
  } agent_t;

  typedef struct packed {
    logic blocked;
    logic support;
  } cmp_res_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_WALK
  } fwc_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT,
    CFG_RADIUS_X,
    CFG_RADIUS_Y,
    CFG_RADIUS_Z
  } cfg_index_e;

endpackage

`default_nettype wire

/* hdl/fwc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/fwc_box_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_box_cmp
  import fwc_pkg::*;
(
  input  wire entry_t   ent_i,
  input  wire agent_t   agent_i,
  output cmp_res_t      res_o
);

  logic [2:0] box_in_agent;
  logic [2:0] agent_in_box;
  logic [2:0] contained;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    edge_t blo, bhi, alo, ahi;
    assign blo = ent_i.lo[k];
    assign bhi = ent_i.hi[k];
    assign alo = agent_i.lo[k];
    assign ahi = agent_i.hi[k];
    assign box_in_agent[k] = ((blo >= alo) && (blo <= ahi)) || ((bhi >= alo) && (bhi <= ahi));
    assign agent_in_box[k] = ((alo >= blo) && (alo <= bhi)) || ((ahi >= blo) && (ahi <= bhi));
    assign contained[k]    = (alo >= blo) && (ahi <= bhi);
  end

  assign res_o.blocked = (&box_in_agent) || (&agent_in_box);
  assign res_o.support = (ent_i.lo[AX_Y] == ent_i.hi[AX_Y]) && ent_i.on_ground
                         && contained[AX_X] && contained[AX_Z];

endmodule

`default_nettype wire

/* hdl/footprint_walkability_check.sv */
`timescale 1ns / 1ps
`default_nettype none

// footprint walkability check. a write item (opcode 0) stores one obstacle box in the table
// and is acknowledged by a done_o strobe; busy_o is high for one cycle. a query item (opcode 1)
// builds the agent box around the point and walks the first obstacle_count table entries
// (clamped to MAX_OBSTACLES), one entry per cycle through the single read port of the obstacle
// table and one shared box compare unit. a query stops early at the first blocking entry. the
// result of every item strobes in the first cycle with busy_o low, and no new item is accepted
// while busy_o is high. results are valid on walkable_o and was_query_o with the done_o strobe,
// which is high for exactly one cycle; the receiver cannot stall them. configuration writes are
// always accepted and must only be issued while the block is idle.
module footprint_walkability_check
  import fwc_pkg::*;
#(
  parameter int unsigned MAX_OBSTACLES = 64,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,

  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic                      opcode_i,
  input  wire logic [SLOT_W-1:0]         slot_i,
  input  wire logic signed [COORD_W-1:0] box_center_x_i,
  input  wire logic signed [COORD_W-1:0] box_center_y_i,
  input  wire logic signed [COORD_W-1:0] box_center_z_i,
  input  wire logic [HALF_W-1:0]         box_half_x_i,
  input  wire logic [HALF_W-1:0]         box_half_y_i,
  input  wire logic [HALF_W-1:0]         box_half_z_i,
  input  wire logic signed [COORD_W-1:0] point_x_i,
  input  wire logic signed [COORD_W-1:0] point_y_i,
  input  wire logic signed [COORD_W-1:0] point_z_i,

  output logic                           done_o,
  output logic                           walkable_o,
  output logic                           was_query_o,

  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ADDR_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam edge_t FRAC_MASK = edge_t'((1 << FRACTION_BITS) - 1);
  localparam edge_t ONE_UNIT  = edge_t'(1 << FRACTION_BITS);

  function automatic edge_t trunc_unit(edge_t s);
    edge_t t;
    t = s & ~FRAC_MASK;
    if (s[EDGE_W-1] && ((s & FRAC_MASK) != '0)) begin
      t = edge_t'(t + ONE_UNIT);
    end
    return t;
  endfunction

  fwc_state_e state_q, state_d;

  logic [COUNT_W-1:0] count_q;
  logic [HALF_W-1:0]  radius_q [3];

  logic                      op_q;
  logic [SLOT_W-1:0]         slot_q;
  logic signed [COORD_W-1:0] cen_q [3];
  logic [HALF_W-1:0]         half_q [3];
  logic signed [COORD_W-1:0] pt_q [3];

  agent_t             agent_q, agent_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               vld_q, vld_d;
  logic               walk_q, walk_d;
  logic               done_q, walkable_q, was_query_q;

  logic               accept;
  logic               rd_en, wr_en, load_agent, fin, fin_walk;
  logic               slot_ok;
  logic [CNT_W-1:0]   lim;
  entry_t             wr_ent, rd_ent;
  cmp_res_t           cmp_res;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign walkable_o  = walkable_q;
  assign was_query_o = was_query_q;

  assign slot_ok = (32'(slot_q) < MAX_OBSTACLES);
  assign lim = (LIM_W'(count_q) > LIM_W'(MAX_OBSTACLES)) ? CNT_W'(MAX_OBSTACLES)
                                                         : CNT_W'(count_q);

  // obstacle edges for a write, agent box for a query
  always_comb begin
    wr_ent.on_ground = !cen_q[AX_Y][COORD_W-1];
    for (int k = 0; k < 3; k++) begin
      wr_ent.lo[k] = trunc_unit(edge_t'({cen_q[k][COORD_W-1], cen_q[k]}
                                        - {{(EDGE_W-HALF_W){1'b0}}, half_q[k]}));
      wr_ent.hi[k] = trunc_unit(edge_t'({cen_q[k][COORD_W-1], cen_q[k]}
                                        + {{(EDGE_W-HALF_W){1'b0}}, half_q[k]}));
      agent_d.lo[k] = edge_t'({pt_q[k][COORD_W-1], pt_q[k]}
                              - {{(EDGE_W-HALF_W){1'b0}}, radius_q[k]});
      agent_d.hi[k] = edge_t'({pt_q[k][COORD_W-1], pt_q[k]}
                              + {{(EDGE_W-HALF_W){1'b0}}, radius_q[k]});
    end
  end

  fwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(slot_q)),
    .wdata_i (wr_ent),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rd_ent)
  );

  fwc_box_cmp u_cmp (
    .ent_i   (rd_ent),
    .agent_i (agent_q),
    .res_o   (cmp_res)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    vld_d      = 1'b0;
    walk_d     = walk_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_agent = 1'b0;
    fin        = 1'b0;
    fin_walk   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = (opcode_i == OP_QUERY) ? ST_SETUP : ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr_en   = slot_ok;
        fin     = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SETUP: begin
        load_agent = 1'b1;
        rd_en      = (idx_q != lim);
        vld_d      = rd_en;
        idx_d      = CNT_W'(idx_q + CNT_W'(rd_en));
        walk_d     = 1'b0;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        if (vld_q && cmp_res.blocked) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else if (idx_q == lim) begin
          fin      = 1'b1;
          fin_walk = walk_q || (vld_q && cmp_res.support);
          state_d  = ST_IDLE;
        end else begin
          rd_en  = 1'b1;
          vld_d  = 1'b1;
          idx_d  = CNT_W'(idx_q + 1'b1);
          walk_d = walk_q || (vld_q && cmp_res.support);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      vld_q       <= 1'b0;
      walk_q      <= 1'b0;
      done_q      <= 1'b0;
      walkable_q  <= 1'b0;
      was_query_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      vld_q  <= vld_d;
      walk_q <= walk_d;
      done_q <= fin;
      if (fin) begin
        walkable_q  <= fin_walk;
        was_query_q <= op_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      radius_q <= '{default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_COUNT:    count_q         <= cfg_data_i[COUNT_W-1:0];
        CFG_RADIUS_X: radius_q[AX_X]  <= cfg_data_i[HALF_W-1:0];
        CFG_RADIUS_Y: radius_q[AX_Y]  <= cfg_data_i[HALF_W-1:0];
        CFG_RADIUS_Z: radius_q[AX_Z]  <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= opcode_i;
      slot_q       <= slot_i;
      cen_q[AX_X]  <= box_center_x_i;
      cen_q[AX_Y]  <= box_center_y_i;
      cen_q[AX_Z]  <= box_center_z_i;
      half_q[AX_X] <= box_half_x_i;
      half_q[AX_Y] <= box_half_y_i;
      half_q[AX_Z] <= box_half_z_i;
      pt_q[AX_X]   <= point_x_i;
      pt_q[AX_Y]   <= point_y_i;
      pt_q[AX_Z]   <= point_z_i;
    end
    if (load_agent) begin
      agent_q <= agent_d;
    end
  end

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fwc_pkg::*;

  localparam int MAX_OBST    = 64;
  localparam int FRAC_BITS   = 4;
  localparam int WORLD       = 'h800;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic                      opcode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [HALF_W-1:0]         hx;
    logic [HALF_W-1:0]         hy;
    logic [HALF_W-1:0]         hz;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } cmd_t;

  typedef struct packed {
    logic walkable;
    logic was_query;
  } outcome_t;

  typedef struct {
    bit         is_reg;
    cfg_index_e reg_idx;
    int         reg_val;
    cmd_t       cmd;
    bit         typed;
    outcome_t   typed_out;
  } plan_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic                      opcode_i;
  logic [SLOT_W-1:0]         slot_i;
  logic signed [COORD_W-1:0] box_center_x_i;
  logic signed [COORD_W-1:0] box_center_y_i;
  logic signed [COORD_W-1:0] box_center_z_i;
  logic [HALF_W-1:0]         box_half_x_i;
  logic [HALF_W-1:0]         box_half_y_i;
  logic [HALF_W-1:0]         box_half_z_i;
  logic signed [COORD_W-1:0] point_x_i;
  logic signed [COORD_W-1:0] point_y_i;
  logic signed [COORD_W-1:0] point_z_i;
  logic                      done_o;
  logic                      walkable_o;
  logic                      was_query_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  // obstacle table and registers as the block should hold them
  edge_t              obst_lo [MAX_OBST][3];
  edge_t              obst_hi [MAX_OBST][3];
  logic               obst_ground [MAX_OBST];
  logic [COUNT_W-1:0] obst_count;
  logic [HALF_W-1:0]  agent_rx;
  logic [HALF_W-1:0]  agent_ry;
  logic [HALF_W-1:0]  agent_rz;

  outcome_t  pending_outcomes[$];
  plan_row_t directed_plan[$];
  int        error_count;
  int        cycle_count;
  bit        idle_enabled;

  footprint_walkability_check i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .box_center_x_i (box_center_x_i),
    .box_center_y_i (box_center_y_i),
    .box_center_z_i (box_center_z_i),
    .box_half_x_i   (box_half_x_i),
    .box_half_y_i   (box_half_y_i),
    .box_half_z_i   (box_half_z_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .done_o         (done_o),
    .walkable_o     (walkable_o),
    .was_query_o    (was_query_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int rand_between(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // truncation toward zero to whole units
  function automatic edge_t trunc_to_unit(int s);
    int mag;
    mag = (s < 0) ? -s : s;
    mag = (mag >> FRAC_BITS) << FRAC_BITS;
    return edge_t'((s < 0) ? -mag : mag);
  endfunction

  function automatic bit edge_in(int alo, int ahi, int blo, int bhi);
    return (alo >= blo && alo <= bhi) || (ahi >= blo && ahi <= bhi);
  endfunction

  function automatic void store_axis(int slot, int ax, logic signed [COORD_W-1:0] c,
                                     logic [HALF_W-1:0] h);
    obst_lo[slot][ax] = trunc_to_unit(int'(c) - int'(h));
    obst_hi[slot][ax] = trunc_to_unit(int'(c) + int'(h));
  endfunction

  function automatic logic query_walkable(int px, int py, int pz);
    int alo[3];
    int ahi[3];
    int n;
    bit box_in_agent;
    bit agent_in_box;
    bit walk;
    alo[AX_X] = px - int'(agent_rx);
    ahi[AX_X] = px + int'(agent_rx);
    alo[AX_Y] = py - int'(agent_ry);
    ahi[AX_Y] = py + int'(agent_ry);
    alo[AX_Z] = pz - int'(agent_rz);
    ahi[AX_Z] = pz + int'(agent_rz);
    n = (obst_count > MAX_OBST) ? MAX_OBST : int'(obst_count);
    walk = 1'b0;
    for (int i = 0; i < n; i++) begin
      box_in_agent = 1'b1;
      agent_in_box = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (!edge_in(int'(obst_lo[i][k]), int'(obst_hi[i][k]), alo[k], ahi[k]))
          box_in_agent = 1'b0;
        if (!edge_in(alo[k], ahi[k], int'(obst_lo[i][k]), int'(obst_hi[i][k])))
          agent_in_box = 1'b0;
      end
      if (box_in_agent || agent_in_box) return 1'b0;
      if (obst_hi[i][AX_Y] == obst_lo[i][AX_Y] && obst_ground[i] &&
          alo[AX_X] >= obst_lo[i][AX_X] && ahi[AX_X] <= obst_hi[i][AX_X] &&
          alo[AX_Z] >= obst_lo[i][AX_Z] && ahi[AX_Z] <= obst_hi[i][AX_Z])
        walk = 1'b1;
    end
    return walk;
  endfunction

  function automatic outcome_t apply_item(cmd_t c);
    outcome_t o;
    o.walkable  = 1'b0;
    o.was_query = (c.opcode == OP_QUERY);
    if (c.opcode == OP_WRITE) begin
      store_axis(int'(c.slot), AX_X, c.cx, c.hx);
      store_axis(int'(c.slot), AX_Y, c.cy, c.hy);
      store_axis(int'(c.slot), AX_Z, c.cz, c.hz);
      obst_ground[c.slot] = (c.cy >= 0);
    end else begin
      o.walkable = query_walkable(int'(c.px), int'(c.py), int'(c.pz));
    end
    return o;
  endfunction

  function automatic cmd_t random_fields();
    cmd_t c;
    c.opcode = 1'($urandom_range(0, 1));
    c.slot   = SLOT_W'($urandom_range(0, MAX_OBST - 1));
    c.cx     = COORD_W'($urandom);
    c.cy     = COORD_W'($urandom);
    c.cz     = COORD_W'($urandom);
    c.hx     = HALF_W'($urandom);
    c.hy     = HALF_W'($urandom);
    c.hz     = HALF_W'($urandom);
    c.px     = COORD_W'($urandom);
    c.py     = COORD_W'($urandom);
    c.pz     = COORD_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t make_write(int slot, int cx, int cy, int cz, int hx, int hy, int hz);
    cmd_t c;
    c        = random_fields();
    c.opcode = OP_WRITE;
    c.slot   = SLOT_W'(slot);
    c.cx     = COORD_W'(cx);
    c.cy     = COORD_W'(cy);
    c.cz     = COORD_W'(cz);
    c.hx     = HALF_W'(hx);
    c.hy     = HALF_W'(hy);
    c.hz     = HALF_W'(hz);
    return c;
  endfunction

  function automatic cmd_t make_query(int px, int py, int pz);
    cmd_t c;
    c        = random_fields();
    c.opcode = OP_QUERY;
    c.px     = COORD_W'(clamp16(px));
    c.py     = COORD_W'(clamp16(py));
    c.pz     = COORD_W'(clamp16(pz));
    return c;
  endfunction

  // floors, solid boxes and full-range noise
  function automatic cmd_t random_write();
    cmd_t c;
    int   sel;
    c        = random_fields();
    c.opcode = OP_WRITE;
    sel      = $urandom_range(0, 9);
    if (sel < 5) begin
      c.cx = COORD_W'(rand_between(-WORLD, WORLD));
      c.cz = COORD_W'(rand_between(-WORLD, WORLD));
      c.cy = (sel == 4) ? COORD_W'(rand_between(-'h200, -1)) : COORD_W'(rand_between(0, 'h200));
      c.hx = HALF_W'($urandom_range('h40, 'h300));
      c.hz = HALF_W'($urandom_range('h40, 'h300));
      c.hy = HALF_W'($urandom_range(0, 7));
    end else if (sel < 9) begin
      c.cx = COORD_W'(rand_between(-WORLD, WORLD));
      c.cy = COORD_W'(rand_between(-WORLD, WORLD));
      c.cz = COORD_W'(rand_between(-WORLD, WORLD));
      c.hx = HALF_W'($urandom_range(0, 'h100));
      c.hy = HALF_W'($urandom_range(0, 'h100));
      c.hz = HALF_W'($urandom_range(0, 'h100));
    end
    return c;
  endfunction

  // mostly points above a stored box, some on its top face
  function automatic cmd_t random_query();
    int n;
    int s;
    int sel;
    int px;
    int py;
    int pz;
    n   = (obst_count > MAX_OBST) ? MAX_OBST : int'(obst_count);
    sel = $urandom_range(0, 9);
    if (n > 0 && sel < 6) begin
      s  = $urandom_range(0, n - 1);
      px = rand_between(int'(obst_lo[s][AX_X]), int'(obst_hi[s][AX_X]));
      pz = rand_between(int'(obst_lo[s][AX_Z]), int'(obst_hi[s][AX_Z]));
      py = int'(obst_hi[s][AX_Y]) + int'(agent_ry);
      if (sel != 0) py = py + rand_between(1, 'h20);
      return make_query(px, py, pz);
    end else if (sel < 9) begin
      return make_query(rand_between(-WORLD, WORLD), rand_between(-WORLD, WORLD),
                        rand_between(-WORLD, WORLD));
    end
    return make_query(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                      int'($signed(16'($urandom))));
  endfunction

  function automatic void append_plan_row(plan_row_t r);
    directed_plan.insert(directed_plan.size(), r);
  endfunction

  function automatic void append_outcome(outcome_t o);
    pending_outcomes.insert(pending_outcomes.size(), o);
  endfunction

  function automatic void add_item(cmd_t c, bit typed, logic exp_walk);
    plan_row_t r;
    r.is_reg              = 1'b0;
    r.reg_idx             = CFG_COUNT;
    r.reg_val             = 0;
    r.cmd                 = c;
    r.typed               = typed;
    r.typed_out.walkable  = exp_walk;
    r.typed_out.was_query = (c.opcode == OP_QUERY);
    append_plan_row(r);
  endfunction

  function automatic void add_reg(cfg_index_e idx, int val);
    plan_row_t r;
    r.is_reg    = 1'b1;
    r.reg_idx   = idx;
    r.reg_val   = val;
    r.cmd       = '0;
    r.typed     = 1'b0;
    r.typed_out = '0;
    append_plan_row(r);
  endfunction

  task automatic issue(input cmd_t c, input bit typed, input outcome_t typed_out);
    outcome_t predicted;
    int       gap;
    gap = (idle_enabled && $urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    opcode_i       <= c.opcode;
    slot_i         <= c.slot;
    box_center_x_i <= c.cx;
    box_center_y_i <= c.cy;
    box_center_z_i <= c.cz;
    box_half_x_i   <= c.hx;
    box_half_y_i   <= c.hy;
    box_half_z_i   <= c.hz;
    point_x_i      <= c.px;
    point_y_i      <= c.py;
    point_z_i      <= c.pz;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predicted = apply_item(c);
    append_outcome(typed ? typed_out : predicted);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_COUNT:    obst_count = val[COUNT_W-1:0];
      CFG_RADIUS_X: agent_rx   = val[HALF_W-1:0];
      CFG_RADIUS_Y: agent_ry   = val[HALF_W-1:0];
      CFG_RADIUS_Z: agent_rz   = val[HALF_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    outcome_t exp_out;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result with nothing pending: walkable %0b was_query %0b",
                   walkable_o, was_query_o);
      end else begin
        exp_out = pending_outcomes.pop_front();
        if (walkable_o !== exp_out.walkable || was_query_o !== exp_out.was_query) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: walkable exp %0b got %0b, was_query exp %0b got %0b",
                     exp_out.walkable, walkable_o, exp_out.was_query, was_query_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    int   cnt;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = OP_WRITE;
    slot_i         = '0;
    box_center_x_i = '0;
    box_center_y_i = '0;
    box_center_z_i = '0;
    box_half_x_i   = '0;
    box_half_y_i   = '0;
    box_half_z_i   = '0;
    point_x_i      = '0;
    point_y_i      = '0;
    point_z_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_COUNT;
    cfg_data_i     = '0;
    error_count    = 0;
    cycle_count    = 0;
    idle_enabled   = 1'b1;
    obst_count     = '0;
    agent_rx       = '0;
    agent_ry       = '0;
    agent_rz       = '0;
    for (int i = 0; i < MAX_OBST; i++) begin
      obst_ground[i] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        obst_lo[i][k] = '0;
        obst_hi[i][k] = '0;
      end
    end

    // queries with reset registers see no entries
    add_item(make_query(0, 0, 0), 1'b1, 1'b0);
    add_item(make_query(-32768, 32767, -32768), 1'b1, 1'b0);
    add_reg(CFG_COUNT, 4);
    add_reg(CFG_RADIUS_X, 'h18);
    add_reg(CFG_RADIUS_Y, 'h10);
    add_reg(CFG_RADIUS_Z, 'h18);
    add_item(make_write(0, 0, 0, 0, 'h100, 0, 'h100), 1'b1, 1'b0);
    add_item(make_write(1, 'h400, -'h20, 0, 'h80, 0, 'h80), 1'b1, 1'b0);
    add_item(make_write(2, 32767, -32768, 32767, 32767, 32767, 32767), 1'b1, 1'b0);
    add_item(make_write(3, -32768, -32768, -32768, 0, 0, 0), 1'b1, 1'b0);
    add_item(make_query(0, 'h20, 0), 1'b0, 1'b0);
    add_item(make_query(0, 'h10, 0), 1'b0, 1'b0);
    add_item(make_query('hf0, 'h20, 0), 1'b0, 1'b0);
    add_item(make_query('he8, 'h20, 'he8), 1'b0, 1'b0);
    add_item(make_query('h400, 0, 0), 1'b0, 1'b0);
    // edges that need truncation, still flat after it
    add_item(make_write(0, 'h0f, 'h25, -'h0f, 'h107, 3, 'h107), 1'b1, 1'b0);
    add_item(make_query(0, 'h31, 0), 1'b0, 1'b0);
    add_item(make_query(-32768, -32768, -32768), 1'b0, 1'b0);
    add_reg(CFG_RADIUS_X, 32767);
    add_reg(CFG_RADIUS_Y, 0);
    add_reg(CFG_RADIUS_Z, 32767);
    add_item(make_query(0, 'h40, 0), 1'b0, 1'b0);
    add_reg(CFG_RADIUS_X, 0);
    add_reg(CFG_RADIUS_Y, 32767);
    add_reg(CFG_RADIUS_Z, 0);
    add_item(make_query(32767, -32768, 32767), 1'b0, 1'b0);
    add_item(make_query(-32768, 32767, -32768), 1'b0, 1'b0);
    add_reg(CFG_COUNT, 0);
    add_item(make_query(32767, 32767, 32767), 1'b1, 1'b0);
    add_item(make_write(63, -32768, 32767, -32768, 32767, 32767, 32767), 1'b1, 1'b0);
    add_item(make_write(62, 32767, 0, -1, 0, 0, 0), 1'b1, 1'b0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        drain();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        issue(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].typed_out);
      end
    end

    // fill the whole table so any count is legal
    for (int s = 0; s < MAX_OBST; s++) begin
      c      = random_write();
      c.slot = SLOT_W'(s);
      issue(c, 1'b0, '0);
    end

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0:       cnt = 64;
        1:       cnt = 127;
        2:       cnt = 0;
        3:       cnt = 1;
        default: cnt = $urandom_range(2, 80);
      endcase
      write_reg(CFG_COUNT, ($urandom_range(0, 255) << COUNT_W) | cnt);
      if (p == 4) begin
        write_reg(CFG_RADIUS_X, 32767);
        write_reg(CFG_RADIUS_Y, 32767);
        write_reg(CFG_RADIUS_Z, 32767);
      end else if (p == 5) begin
        write_reg(CFG_RADIUS_X, 0);
        write_reg(CFG_RADIUS_Y, 0);
        write_reg(CFG_RADIUS_Z, 0);
      end else begin
        write_reg(CFG_RADIUS_X, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                            : $urandom_range(0, 'h40));
        write_reg(CFG_RADIUS_Y, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                            : $urandom_range(0, 'h40));
        write_reg(CFG_RADIUS_Z, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                            : $urandom_range(0, 'h40));
      end
      // one long stretch with the sender never idling
      idle_enabled = (p != 6);
      for (int j = 0; j < 110; j++) begin
        if (p == 7 && j == 55) drain();
        if ($urandom_range(0, 99) < 30) issue(random_write(), 1'b0, '0);
        else issue(random_query(), 1'b0, '0);
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
